// ===== design/oukl_pkg.sv =====
// ----------------------------------------------------------------------------
// oukl_pkg
// Shared types, sizes and codes for the ordered unique key list.
// ----------------------------------------------------------------------------
package oukl_pkg;

    localparam int CAPACITY = 64;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = 7;
    localparam int KEY_W    = 32;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 3;

    typedef logic [SLOT_W-1:0]       t_slot;
    typedef logic [COUNT_W-1:0]      t_count;
    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic [OP_W-1:0]         t_opcode;
    typedef logic [STATUS_W-1:0]     t_status;

    // opcodes
    localparam t_opcode OP_APPEND    = 3'd0;
    localparam t_opcode OP_REM_FIRST = 3'd1;
    localparam t_opcode OP_REM_MID   = 3'd2;
    localparam t_opcode OP_REM_LAST  = 3'd3;
    localparam t_opcode OP_DUMP      = 3'd4;

    // status codes
    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_EMPTY    = 3'd1;
    localparam t_status ST_DUP      = 3'd2;
    localparam t_status ST_FULL     = 3'd3;
    localparam t_status ST_FEW      = 3'd4;
    localparam t_status ST_NOTFOUND = 3'd5;
    localparam t_status ST_ISLAST   = 3'd6;

endpackage

// ===== design/oukl_in_if.sv =====
// ----------------------------------------------------------------------------
// oukl_in_if
// Command channel: opcode and key, valid/ready handshake.
// ----------------------------------------------------------------------------
interface oukl_in_if;

    logic              valid;
    logic              ready;
    oukl_pkg::t_opcode opcode;
    oukl_pkg::t_key    key;

    modport source (output valid, output opcode, output key, input ready);
    modport sink   (input valid, input opcode, input key, output ready);

endinterface

// ===== design/oukl_out_if.sv =====
// ----------------------------------------------------------------------------
// oukl_out_if
// Result channel: status, key, entry count and last flag, valid/ready.
// ----------------------------------------------------------------------------
interface oukl_out_if;

    logic              valid;
    logic              ready;
    oukl_pkg::t_status status;
    oukl_pkg::t_key    out_key;
    oukl_pkg::t_count  entry_count;
    logic              last;

    modport source (output valid, output status, output out_key, output entry_count,
                    output last, input ready);
    modport sink   (input valid, input status, input out_key, input entry_count,
                    input last, output ready);

endinterface

// ===== design/ordered_unique_key_list.sv =====
// ----------------------------------------------------------------------------
// ordered_unique_key_list
// Ordered list of unique signed keys kept as a ring of linked slots in two
// synchronous memories (keys, links) with a free map of slots.
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake      payload
//   i_item    in   valid/ready    opcode, key
//   o_res     out  valid/ready    status, out_key, entry_count, last
//
// One command at a time. A walking command holds the block until its result
// is loaded into the result register. The walk reads one linked slot per cycle
// through the single read port of the key and link memories, while the result
// channel does not stall. Empty, too-few and unknown commands finish in the
// start state; an unknown command gives no result.
// Reset is synchronous and active low; the memories need no clearing pass,
// the free map and list pointers come out of reset at once.
// A stalled result holds the walk: the current slot is simply re-read.
// ----------------------------------------------------------------------------
module ordered_unique_key_list (
    input  logic        i_clk,
    input  logic        i_rst_n,
    oukl_in_if.sink     i_item,
    oukl_out_if.source  o_res
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_ALLOC = 3'd3;
    localparam logic [2:0] S_LINK  = 3'd4;

    localparam oukl_pkg::t_count CAP_COUNT = oukl_pkg::COUNT_W'(oukl_pkg::CAPACITY);

    // Slot memories
    oukl_pkg::t_key  key_mem  [oukl_pkg::CAPACITY];
    oukl_pkg::t_slot link_mem [oukl_pkg::CAPACITY];

    // Control state
    logic [2:0]                    r_state, n_state;
    oukl_pkg::t_slot               r_first, n_first;
    oukl_pkg::t_slot               r_last,  n_last;
    oukl_pkg::t_count              r_count, n_count;
    logic [oukl_pkg::CAPACITY-1:0] r_free,  n_free;
    logic                          r_out_valid;

    // Command and walk registers
    oukl_pkg::t_opcode r_op,   n_op;
    oukl_pkg::t_key    r_key,  n_key;
    oukl_pkg::t_slot   r_cur,  n_cur;
    oukl_pkg::t_slot   r_prev, n_prev;
    oukl_pkg::t_slot   r_pos,  n_pos;
    oukl_pkg::t_slot   r_slot;
    oukl_pkg::t_key    r_key_rd;
    oukl_pkg::t_slot   r_link_rd;

    // Result register
    oukl_pkg::t_status r_out_status;
    oukl_pkg::t_key    r_out_key;
    oukl_pkg::t_count  r_out_count;
    logic              r_out_last;

    // Combinational control
    logic              w_out_free;
    logic              w_load;
    oukl_pkg::t_status w_status;
    oukl_pkg::t_key    w_okey;
    logic              w_olast;
    logic              w_is_end;
    logic              w_match;
    oukl_pkg::t_slot   w_rd_addr;
    logic              w_key_we;
    logic              w_link_we;
    oukl_pkg::t_slot   w_link_addr;
    oukl_pkg::t_slot   w_link_data;
    oukl_pkg::t_slot   w_low_free;

    assign i_item.ready      = (r_state == S_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out_status;
    assign o_res.out_key     = r_out_key;
    assign o_res.entry_count = r_out_count;
    assign o_res.last        = r_out_last;

    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_is_end   = (oukl_pkg::COUNT_W'(r_pos) == r_count - oukl_pkg::COUNT_W'(1));
    assign w_match    = (r_key_rd == r_key);

    // Lowest free slot, registered; the map does not change while a command is
    // in flight, so the slot is settled before any allocation uses it.
    always_comb begin
        w_low_free = '0;
        for (int i = oukl_pkg::CAPACITY - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                w_low_free = oukl_pkg::SLOT_W'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_first     = r_first;
        n_last      = r_last;
        n_count     = r_count;
        n_free      = r_free;
        n_op        = r_op;
        n_key       = r_key;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_pos       = r_pos;
        w_load      = 1'b0;
        w_status    = oukl_pkg::ST_OK;
        w_okey      = '0;
        w_olast     = 1'b1;
        w_rd_addr   = r_cur;
        w_key_we    = 1'b0;
        w_link_we   = 1'b0;
        w_link_addr = r_slot;
        w_link_data = r_slot;

        case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_op    = i_item.opcode;
                    n_key   = i_item.key;
                    n_state = S_START;
                end
            end

            S_START: begin
                // launch the read of the head slot
                n_cur     = r_first;
                n_prev    = r_first;
                n_pos     = '0;
                w_rd_addr = r_first;
                case (r_op)
                    oukl_pkg::OP_APPEND: begin
                        n_state = (r_count == '0) ? S_ALLOC : S_WALK;
                    end
                    oukl_pkg::OP_REM_FIRST, oukl_pkg::OP_REM_LAST, oukl_pkg::OP_DUMP: begin
                        if (r_count == '0) begin
                            w_status = oukl_pkg::ST_EMPTY;
                            if (w_out_free) begin
                                w_load  = 1'b1;
                                n_state = S_IDLE;
                            end
                        end else begin
                            n_state = S_WALK;
                        end
                    end
                    oukl_pkg::OP_REM_MID: begin
                        if (r_count == '0) begin
                            w_status = oukl_pkg::ST_EMPTY;
                            if (w_out_free) begin
                                w_load  = 1'b1;
                                n_state = S_IDLE;
                            end
                        end else if (r_count < oukl_pkg::COUNT_W'(3)) begin
                            w_status = oukl_pkg::ST_FEW;
                            if (w_out_free) begin
                                w_load  = 1'b1;
                                n_state = S_IDLE;
                            end
                        end else begin
                            n_state = S_WALK;
                        end
                    end
                    default: begin
                        // unknown opcode: no result
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_WALK: begin
                // r_key_rd / r_link_rd hold the slot r_cur at position r_pos
                case (r_op)
                    oukl_pkg::OP_APPEND: begin
                        if (w_match) begin
                            w_status = oukl_pkg::ST_DUP;
                            if (w_out_free) begin
                                w_load  = 1'b1;
                                n_state = S_IDLE;
                            end
                        end else if (w_is_end) begin
                            if (r_count >= CAP_COUNT) begin
                                w_status = oukl_pkg::ST_FULL;
                                if (w_out_free) begin
                                    w_load  = 1'b1;
                                    n_state = S_IDLE;
                                end
                            end else begin
                                n_state = S_ALLOC;
                            end
                        end else begin
                            n_cur     = r_link_rd;
                            n_prev    = r_cur;
                            n_pos     = r_pos + oukl_pkg::SLOT_W'(1);
                            w_rd_addr = r_link_rd;
                        end
                    end

                    oukl_pkg::OP_REM_FIRST: begin
                        w_okey = r_key_rd;
                        if (w_out_free) begin
                            w_load        = 1'b1;
                            n_state       = S_IDLE;
                            n_free[r_cur] = 1'b1;
                            if (r_count == oukl_pkg::COUNT_W'(1)) begin
                                n_first = '0;
                                n_last  = '0;
                                n_count = '0;
                            end else begin
                                n_first     = r_link_rd;
                                n_count     = r_count - oukl_pkg::COUNT_W'(1);
                                w_link_we   = 1'b1;
                                w_link_addr = r_last;
                                w_link_data = r_link_rd;
                            end
                        end
                    end

                    oukl_pkg::OP_REM_LAST: begin
                        if (w_is_end) begin
                            w_okey = r_key_rd;
                            if (w_out_free) begin
                                w_load        = 1'b1;
                                n_state       = S_IDLE;
                                n_free[r_cur] = 1'b1;
                                if (r_count == oukl_pkg::COUNT_W'(1)) begin
                                    n_first = '0;
                                    n_last  = '0;
                                    n_count = '0;
                                end else begin
                                    n_last      = r_prev;
                                    n_count     = r_count - oukl_pkg::COUNT_W'(1);
                                    w_link_we   = 1'b1;
                                    w_link_addr = r_prev;
                                    w_link_data = r_first;
                                end
                            end
                        end else begin
                            n_cur     = r_link_rd;
                            n_prev    = r_cur;
                            n_pos     = r_pos + oukl_pkg::SLOT_W'(1);
                            w_rd_addr = r_link_rd;
                        end
                    end

                    oukl_pkg::OP_REM_MID: begin
                        if (r_pos != '0 && w_match) begin
                            if (w_is_end) begin
                                w_status = oukl_pkg::ST_ISLAST;
                                if (w_out_free) begin
                                    w_load  = 1'b1;
                                    n_state = S_IDLE;
                                end
                            end else begin
                                w_okey = r_key;
                                if (w_out_free) begin
                                    w_load        = 1'b1;
                                    n_state       = S_IDLE;
                                    n_free[r_cur] = 1'b1;
                                    n_count       = r_count - oukl_pkg::COUNT_W'(1);
                                    w_link_we     = 1'b1;
                                    w_link_addr   = r_prev;
                                    w_link_data   = r_link_rd;
                                end
                            end
                        end else if (w_is_end) begin
                            w_status = oukl_pkg::ST_NOTFOUND;
                            if (w_out_free) begin
                                w_load  = 1'b1;
                                n_state = S_IDLE;
                            end
                        end else begin
                            n_cur     = r_link_rd;
                            n_prev    = r_cur;
                            n_pos     = r_pos + oukl_pkg::SLOT_W'(1);
                            w_rd_addr = r_link_rd;
                        end
                    end

                    oukl_pkg::OP_DUMP: begin
                        w_okey  = r_key_rd;
                        w_olast = w_is_end;
                        if (w_out_free) begin
                            w_load = 1'b1;
                            if (w_is_end) begin
                                n_state = S_IDLE;
                            end else begin
                                n_cur     = r_link_rd;
                                n_prev    = r_cur;
                                n_pos     = r_pos + oukl_pkg::SLOT_W'(1);
                                w_rd_addr = r_link_rd;
                            end
                        end
                    end

                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_ALLOC: begin
                // new slot: store key, close the ring back to the head
                w_key_we    = 1'b1;
                w_link_we   = 1'b1;
                w_link_addr = r_slot;
                w_link_data = (r_count == '0) ? r_slot : r_first;
                if (r_count == '0) begin
                    if (w_out_free) begin
                        w_load         = 1'b1;
                        n_state        = S_IDLE;
                        n_first        = r_slot;
                        n_last         = r_slot;
                        n_count        = oukl_pkg::COUNT_W'(1);
                        n_free[r_slot] = 1'b0;
                    end
                end else begin
                    n_state = S_LINK;
                end
            end

            S_LINK: begin
                // old tail now points at the new slot
                w_link_we   = 1'b1;
                w_link_addr = r_last;
                w_link_data = r_slot;
                if (w_out_free) begin
                    w_load         = 1'b1;
                    n_state        = S_IDLE;
                    n_last         = r_slot;
                    n_count        = r_count + oukl_pkg::COUNT_W'(1);
                    n_free[r_slot] = 1'b0;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_first     <= '0;
            r_last      <= '0;
            r_count     <= '0;
            r_free      <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_first <= n_first;
            r_last  <= n_last;
            r_count <= n_count;
            r_free  <= n_free;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_key  <= n_key;
        r_cur  <= n_cur;
        r_prev <= n_prev;
        r_pos  <= n_pos;
        r_slot <= w_low_free;
        if (w_load) begin
            r_out_status <= w_status;
            r_out_key    <= w_okey;
            r_out_count  <= n_count;
            r_out_last   <= w_olast;
        end
    end

    // Key and link memories, one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (w_key_we) begin
            key_mem[r_slot] <= r_key;
        end
        if (w_link_we) begin
            link_mem[w_link_addr] <= w_link_data;
        end
        r_key_rd  <= key_mem[w_rd_addr];
        r_link_rd <= link_mem[w_rd_addr];
    end

`ifndef SYNTH
    // every slot is either free or holds an entry
    a_slot_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(r_free) + int'(r_count)) == oukl_pkg::CAPACITY)
        else $error("free map and entry count disagree");

    // the list only changes together with a result being issued
    a_count_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_load |=> $stable(r_count))
        else $error("entry count changed without a result");

    // commands are taken only when no walk is in flight
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> (r_state == S_START))
        else $error("accepted command did not start");
`endif

endmodule
